/* src/tws_pkg.sv */
`default_nettype none

package tws_pkg;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned LETTER_W = 5;

  // operation codes carried in the mode field
  localparam logic [MODE_W-1:0] MODE_INSERT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEARCH   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PREFIX   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;  // acts as prefix test

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_ALLOC,
    ST_MARK,
    ST_DONE
  } tws_state_e;

  // write strobes into the node store
  typedef struct packed {
    logic row_clr;   // zero a whole child row
    logic lane_we;   // write one child slot
    logic mark_we;   // write the word-end mark
    logic mark_val;
  } wr_ctl_t;

endpackage

`default_nettype wire

/* src/tws_if.sv */
`default_nettype none

interface tws_in_if;
  logic                          valid;
  logic                          ready;
  logic [tws_pkg::MODE_W-1:0]    mode;
  logic [tws_pkg::LETTER_W-1:0]  letter;
  logic                          has_letter;
  logic                          last;

  modport source (output valid, mode, letter, has_letter, last, input ready);
  modport sink   (input valid, mode, letter, has_letter, last, output ready);
endinterface

interface tws_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic overflow;

  modport source (output valid, hit, overflow, input ready);
  modport sink   (input valid, hit, overflow, output ready);
endinterface

`default_nettype wire

/* src/tws_store.sv */
`default_nettype none

module tws_store #(
  parameter int unsigned MAX_NODES = 1024,
  parameter int unsigned ALPHABET  = 26,
  localparam int unsigned NODE_W   = $clog2(MAX_NODES),
  localparam int unsigned LANE_W   = $clog2(ALPHABET)
) (
  input  wire logic                             clk_i,
  input  wire logic [NODE_W-1:0]                rd_node_i,
  input  wire tws_pkg::wr_ctl_t                 wr_ctl_i,
  input  wire logic [NODE_W-1:0]                wr_node_i,
  input  wire logic [LANE_W-1:0]                wr_lane_i,
  input  wire logic [NODE_W-1:0]                wr_child_i,
  output logic      [ALPHABET-1:0][NODE_W-1:0]  row_o,
  output logic                                  mark_o
);

  // one row of child slots per node, one word-end bit per node
  logic [ALPHABET-1:0][NODE_W-1:0] child_mem [MAX_NODES];
  logic                            mark_mem  [MAX_NODES];

  always_ff @(posedge clk_i) begin
    if (wr_ctl_i.row_clr) begin
      child_mem[wr_node_i] <= '0;
    end else if (wr_ctl_i.lane_we) begin
      child_mem[wr_node_i][wr_lane_i] <= wr_child_i;
    end
    row_o <= child_mem[rd_node_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_ctl_i.mark_we) begin
      mark_mem[wr_node_i] <= wr_ctl_i.mark_val;
    end
    mark_o <= mark_mem[rd_node_i];
  end

endmodule

`default_nettype wire

/* src/trie_word_store.sv */
// trie_word_store: lowercase word store kept as a 26-way trie in a fixed
// node pool. Words stream in on in_i, one letter code per beat, with the
// operation (insert, search word, prefix test) and a last flag; a beat with
// has_letter low carries no letter and serves to close a word. The beat with
// last high yields one result beat on out_o: hit, and overflow when an insert
// found the pool full (the word then stays unstored).
// Timing: a letter beat occupies the walker for a row read, then a child
// check (ST_LOOK), plus an allocation step (ST_ALLOC) when a new node is
// needed, since the parent slot and the new row share the one write port
// of the node store. The last beat of a word adds the word-end mark read
// (ST_MARK) and the result step (ST_DONE) that loads the result register;
// a last beat that walks no letter goes straight to the mark read.
// in_i.ready is low while a beat is being worked on.
// Reset: the walker returns to the root and the pool counter to 1. The node
// rows are never swept; each row and mark is zeroed when its node is
// allocated, and the root row is zeroed by ST_INIT right after reset,
// during which in_i.ready stays low.
// Stall: the result sits in an output register; the next word is taken
// meanwhile, and its result waits in the final step until out_o is free.
`default_nettype none

module trie_word_store #(
  parameter int unsigned MAX_NODES = 1024,
  parameter int unsigned ALPHABET  = 26
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tws_in_if.sink     in_i,
  tws_out_if.source  out_o
);

  localparam int unsigned NODE_W = $clog2(MAX_NODES);
  localparam int unsigned CNT_W  = $clog2(MAX_NODES + 1);
  localparam int unsigned LANE_W = $clog2(ALPHABET);

  tws_pkg::tws_state_e state_q, state_d;

  // walk state
  logic [NODE_W-1:0] cur_q, cur_d;
  logic [CNT_W-1:0]  next_free_q, next_free_d;
  logic              missed_q, missed_d;
  logic              exh_q, exh_d;

  // captured beat
  logic [tws_pkg::MODE_W-1:0]   mode_q, mode_d;
  logic [tws_pkg::LETTER_W-1:0] letter_q, letter_d;
  logic                         last_q, last_d;

  // result register
  logic out_valid_q, out_valid_d;
  logic hit_q, hit_d;
  logic ovf_q, ovf_d;

  // store port
  tws_pkg::wr_ctl_t                wr_ctl;
  logic [NODE_W-1:0]               wr_node;
  logic [ALPHABET-1:0][NODE_W-1:0] row;
  logic                            mark;

  logic [LANE_W-1:0] lane;
  logic [NODE_W-1:0] child;
  logic              walk;
  logic              in_range;
  logic              pool_full;
  logic              is_insert;

  assign lane      = letter_q[LANE_W-1:0];
  assign child     = row[lane];
  assign walk      = in_i.has_letter && !missed_q && !exh_q;
  assign in_range  = {1'b0, in_i.letter} < (tws_pkg::LETTER_W + 1)'(ALPHABET);
  assign pool_full = next_free_q == CNT_W'(MAX_NODES);
  assign is_insert = mode_q == tws_pkg::MODE_INSERT;

  assign in_i.ready     = state_q == tws_pkg::ST_IDLE;
  assign out_o.valid    = out_valid_q;
  assign out_o.hit      = hit_q;
  assign out_o.overflow = ovf_q;

  tws_store #(
    .MAX_NODES (MAX_NODES),
    .ALPHABET  (ALPHABET)
  ) u_store (
    .clk_i      (clk_i),
    .rd_node_i  (cur_q),
    .wr_ctl_i   (wr_ctl),
    .wr_node_i  (wr_node),
    .wr_lane_i  (lane),
    .wr_child_i (next_free_q[NODE_W-1:0]),
    .row_o      (row),
    .mark_o     (mark)
  );

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    next_free_d = next_free_q;
    missed_d    = missed_q;
    exh_d       = exh_q;
    mode_d      = mode_q;
    letter_d    = letter_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_o.ready;
    hit_d       = hit_q;
    ovf_d       = ovf_q;
    wr_ctl      = '0;
    wr_node     = cur_q;

    unique case (state_q)
      tws_pkg::ST_INIT: begin
        // zero root row and mark
        wr_ctl.row_clr  = 1'b1;
        wr_ctl.mark_we  = 1'b1;
        wr_ctl.mark_val = 1'b0;
        wr_node         = '0;
        state_d         = tws_pkg::ST_IDLE;
      end

      tws_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          mode_d   = in_i.mode;
          letter_d = in_i.letter;
          last_d   = in_i.last;
          if (walk && !in_range) begin
            missed_d = 1'b1;
          end
          // row of cur_q is read at this edge
          if (walk && in_range) begin
            state_d = tws_pkg::ST_LOOK;
          end else if (in_i.last) begin
            state_d = tws_pkg::ST_MARK;
          end
        end
      end

      tws_pkg::ST_LOOK: begin
        state_d = last_q ? tws_pkg::ST_MARK : tws_pkg::ST_IDLE;
        if (child != '0) begin
          cur_d = child;
        end else if (!is_insert) begin
          missed_d = 1'b1;
        end else if (pool_full) begin
          exh_d = 1'b1;
        end else begin
          // link new node into parent slot
          wr_ctl.lane_we = 1'b1;
          state_d        = tws_pkg::ST_ALLOC;
        end
      end

      tws_pkg::ST_ALLOC: begin
        wr_ctl.row_clr  = 1'b1;
        wr_ctl.mark_we  = 1'b1;
        wr_ctl.mark_val = 1'b0;
        wr_node         = next_free_q[NODE_W-1:0];
        cur_d           = next_free_q[NODE_W-1:0];
        next_free_d     = next_free_q + CNT_W'(1);
        state_d         = last_q ? tws_pkg::ST_MARK : tws_pkg::ST_IDLE;
      end

      tws_pkg::ST_MARK: begin
        // mark of cur_q is read at this edge
        state_d = tws_pkg::ST_DONE;
      end

      tws_pkg::ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          hit_d       = 1'b0;
          ovf_d       = 1'b0;
          unique case (mode_q)
            tws_pkg::MODE_INSERT: begin
              if (exh_q) begin
                ovf_d = 1'b1;
              end else if (!missed_q) begin
                hit_d           = 1'b1;
                wr_ctl.mark_we  = 1'b1;
                wr_ctl.mark_val = 1'b1;
              end
            end
            tws_pkg::MODE_SEARCH: begin
              hit_d = !missed_q && mark;
            end
            tws_pkg::MODE_PREFIX, tws_pkg::MODE_RESERVED: begin
              hit_d = !missed_q;
            end
            default: begin
              hit_d = 1'b0;
            end
          endcase
          cur_d    = '0;
          missed_d = 1'b0;
          exh_d    = 1'b0;
          state_d  = tws_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tws_pkg::ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tws_pkg::ST_INIT;
      cur_q       <= '0;
      next_free_q <= CNT_W'(1);
      missed_q    <= 1'b0;
      exh_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      next_free_q <= next_free_d;
      missed_q    <= missed_d;
      exh_q       <= exh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    letter_q <= letter_d;
    last_q   <= last_d;
    hit_q    <= hit_d;
    ovf_q    <= ovf_d;
  end

`ifndef ASSERT_OFF
  // a walk stops at the first miss or exhaustion, never both
  a_miss_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(missed_q && exh_q))
    else $error("missed and exhausted both set");

  // the walker only stands on allocated nodes
  a_cur_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(cur_q) < next_free_q)
    else $error("current node not allocated");

  // allocation only with a free node left
  a_alloc_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tws_pkg::ST_ALLOC) |-> !pool_full)
    else $error("allocation from a full pool");

  // pool counter never shrinks
  a_pool_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != tws_pkg::ST_INIT) |=> next_free_q >= $past(next_free_q))
    else $error("pool counter went back");

  // a result appears only out of the final step
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == tws_pkg::ST_DONE))
    else $error("result without final step");
`endif

endmodule

`default_nettype wire

/* bench/trie_word_store_tb.sv */
// Expected-result tracker for the trie word store. It keeps its own copy of
// the node pool, walks each accepted beat through it and queues one answer
// per beat with last set.
class trie_answer_board #(int unsigned POOL = 1024, int unsigned LETTERS = 26);

  typedef struct packed {
    logic hit;
    logic overflow;
  } answer_t;

  int unsigned kid [POOL*LETTERS];  // 0 = no child, the root is never one
  bit          marked [POOL];
  int unsigned free_ptr;
  int unsigned here;
  bit          lost;                // path left the trie or bad letter code
  bit          full;                // insert found the pool full
  answer_t     due_answers [$];
  int unsigned errors;

  function new();
    foreach (kid[i]) kid[i] = 0;
    foreach (marked[i]) marked[i] = 1'b0;
    free_ptr  = 1;
    here      = 0;
    lost      = 1'b0;
    full      = 1'b0;
    errors    = 0;
  endfunction

  function void take_beat(logic [1:0] op, logic [4:0] code, logic has, logic fin);
    int unsigned slot;
    bit          ins;
    answer_t     ans;
    ins = (op == tws_pkg::MODE_INSERT);
    if (has && !lost && !full) begin
      if (code >= LETTERS) begin
        lost = 1'b1;
      end else begin
        slot = here * LETTERS + code;
        if (kid[slot] == 0) begin
          if (!ins) begin
            lost = 1'b1;
          end else if (free_ptr >= POOL) begin
            full = 1'b1;
          end else begin
            kid[slot] = free_ptr;
            free_ptr++;
          end
        end
        if (!lost && !full) here = kid[slot];
      end
    end
    if (!fin) return;
    ans = '0;
    if (ins) begin
      if (full) begin
        ans.overflow = 1'b1;
      end else if (!lost) begin
        marked[here] = 1'b1;
        ans.hit = 1'b1;
      end
    end else if (op == tws_pkg::MODE_PREFIX || op == tws_pkg::MODE_RESERVED) begin
      ans.hit = !lost;
    end else if (!lost) begin
      ans.hit = marked[here];
    end
    due_answers.push_back(ans);
    here = 0;
    lost = 1'b0;
    full = 1'b0;
  endfunction

  function void check_answer(logic hit, logic overflow);
    answer_t want;
    if (due_answers.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result beat: hit=%0b overflow=%0b", hit, overflow);
      return;
    end
    want = due_answers.pop_front();
    if (hit !== want.hit || overflow !== want.overflow) begin
      errors++;
      if (errors <= 10)
        $display("result mismatch: expected hit=%0b overflow=%0b, got hit=%0b overflow=%0b",
                 want.hit, want.overflow, hit, overflow);
    end
  endfunction

endclass

module trie_word_store_tb;

  localparam int unsigned POOL        = 1024;
  localparam int unsigned LETTERS     = 26;
  localparam int unsigned WORD_BEATS  = 1950;     // random letter/closing beats
  localparam int unsigned CYCLE_LIMIT = 400_000;  // watchdog limit on the cycle count

  typedef trie_answer_board #(POOL, LETTERS) board_t;

  // a word as a letter string, up to 15 letters
  typedef struct packed {
    logic [3:0]       len;
    logic [15:0][4:0] ch;
  } word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tws_in_if  in_bus ();
  tws_out_if out_bus ();

  board_t      board;
  word_t       known_words [$];  // inserted words, reused for later words of any mode
  int unsigned beats_sent;
  int unsigned cycle_count;
  int unsigned src_gap_pct;
  int unsigned sink_gap_pct;

  trie_word_store #(
    .MAX_NODES(POOL),
    .ALPHABET (LETTERS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always #6 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: ready toggles at the falling edge, beats are checked at the
  // rising edge where valid and ready meet.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(0, 99) >= sink_gap_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready)
      board.check_answer(out_bus.hit, out_bus.overflow);
  end

  // One input beat. Called at a falling edge, returns at the falling edge
  // after the beat is taken. valid stays high across back-to-back beats.
  task automatic send_beat(logic [1:0] op, logic [4:0] code, logic has, logic fin);
    while ($urandom_range(0, 99) < src_gap_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.mode       <= op;
    in_bus.letter     <= code;
    in_bus.has_letter <= has;
    in_bus.last       <= fin;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    board.take_beat(op, code, has, fin);
    @(negedge clk_i);
  endtask

  // Random word: mostly fresh or reused words with an optional twist
  // (shortened, extended, one letter changed, a bad code), sometimes closed
  // by an empty beat, sometimes with mixed modes, with filler beats mixed in.
  task automatic send_random_word();
    word_t       w;
    logic [1:0]  op;
    int unsigned pick;
    bit          closer;
    bit          mixed;
    bit          fin;
    pick = $urandom_range(0, 99);
    op = (pick < 45) ? tws_pkg::MODE_INSERT : (pick < 75) ? tws_pkg::MODE_SEARCH :
         (pick < 93) ? tws_pkg::MODE_PREFIX : tws_pkg::MODE_RESERVED;
    if (known_words.size() > 0 && $urandom_range(0, 99) < 50) begin
      w = known_words[$urandom_range(0, known_words.size() - 1)];
      case ($urandom_range(0, 3))
        0: ;
        1: w.len = 4'($urandom_range(0, w.len));
        2: begin
          while (w.len < 15 && $urandom_range(0, 1) == 1) begin
            w.ch[w.len] = 5'($urandom_range(0, LETTERS - 1));
            w.len++;
          end
        end
        default: begin
          if (w.len != 0)
            w.ch[$urandom_range(0, w.len - 1)] = 5'($urandom_range(0, LETTERS - 1));
        end
      endcase
    end else begin
      w.len = (op == tws_pkg::MODE_INSERT) ? 4'($urandom_range(1, 12)) :
                                             4'($urandom_range(1, 8));
      for (int i = 0; i < w.len; i++) w.ch[i] = 5'($urandom_range(0, LETTERS - 1));
      if ($urandom_range(0, 99) < 3) w.len = 4'd0;
    end
    // occasional code past z
    if (w.len != 0 && $urandom_range(0, 99) < 4)
      w.ch[$urandom_range(0, w.len - 1)] = 5'($urandom_range(LETTERS, 31));
    closer = (w.len == 0) || ($urandom_range(0, 3) == 0);
    mixed  = ($urandom_range(0, 99) < 5);
    for (int i = 0; i < w.len; i++) begin
      if ($urandom_range(0, 99) < 5)
        send_beat(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)), 1'b0, 1'b0);
      fin = !closer && (i == w.len - 1);
      send_beat((mixed && !fin) ? 2'($urandom_range(0, 3)) : op, w.ch[i], 1'b1, fin);
      beats_sent++;
    end
    if (closer) begin
      send_beat(op, 5'($urandom_range(0, 31)), 1'b0, 1'b1);
      beats_sent++;
    end
    if (op == tws_pkg::MODE_INSERT) begin
      known_words.push_back(w);
      if (known_words.size() > 300) known_words.delete(0);
    end
  endtask

  initial begin
    board        = new();
    beats_sent   = 0;
    cycle_count  = 0;
    src_gap_pct  = 17;
    sink_gap_pct = 49;
    rst_ni             = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.mode        = tws_pkg::MODE_INSERT;
    in_bus.letter      = '0;
    in_bus.has_letter  = 1'b0;
    in_bus.last        = 1'b0;
    out_bus.ready      = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // --- directed beats ---
    send_beat(tws_pkg::MODE_SEARCH,   5'd0,  1'b0, 1'b1);  // empty word, root not marked yet
    send_beat(tws_pkg::MODE_PREFIX,   5'd31, 1'b0, 1'b1);  // empty prefix always exists
    send_beat(tws_pkg::MODE_INSERT,   5'd0,  1'b0, 1'b1);  // empty word marks the root
    send_beat(tws_pkg::MODE_SEARCH,   5'd21, 1'b0, 1'b1);  // now found
    send_beat(tws_pkg::MODE_INSERT,   5'd25, 1'b1, 1'b1);  // "z"
    send_beat(tws_pkg::MODE_INSERT,   5'd0,  1'b1, 1'b0);  // "a", closed by an empty beat
    send_beat(tws_pkg::MODE_INSERT,   5'd0,  1'b0, 1'b1);
    send_beat(tws_pkg::MODE_SEARCH,   5'd0,  1'b1, 1'b1);  // "a" stored
    send_beat(tws_pkg::MODE_SEARCH,   5'd25, 1'b1, 1'b0);  // "za" not stored
    send_beat(tws_pkg::MODE_SEARCH,   5'd0,  1'b1, 1'b1);
    send_beat(tws_pkg::MODE_SEARCH,   5'd31, 1'b1, 1'b1);  // code past z misses
    send_beat(tws_pkg::MODE_INSERT,   5'd26, 1'b1, 1'b1);  // bad code: no hit, no overflow
    send_beat(tws_pkg::MODE_RESERVED, 5'd25, 1'b1, 1'b1);  // reserved mode acts as prefix
    send_beat(tws_pkg::MODE_PREFIX,   5'd7,  1'b0, 1'b0);  // filler, no result
    send_beat(tws_pkg::MODE_INSERT,   5'd1,  1'b1, 1'b0);  // mixed: b inserted, c searched
    send_beat(tws_pkg::MODE_SEARCH,   5'd2,  1'b1, 1'b1);
    send_beat(tws_pkg::MODE_PREFIX,   5'd1,  1'b1, 1'b1);  // b path was allocated
    send_beat(tws_pkg::MODE_SEARCH,   5'd1,  1'b1, 1'b1);  // but b is not a word
    send_beat(tws_pkg::MODE_INSERT,   5'd25, 1'b1, 1'b0);  // a miss sticks past later letters
    send_beat(tws_pkg::MODE_INSERT,   5'd31, 1'b1, 1'b0);
    send_beat(tws_pkg::MODE_INSERT,   5'd3,  1'b1, 1'b1);
    send_beat(tws_pkg::MODE_SEARCH,   5'd25, 1'b1, 1'b1);  // "z" still a word

    // --- random words, three idling phases ---
    while (beats_sent < WORD_BEATS) begin
      if (beats_sent < WORD_BEATS / 3) begin
        src_gap_pct  = 17;
        sink_gap_pct = 49;
      end else if (beats_sent < 2 * WORD_BEATS / 3) begin
        src_gap_pct  = 49;
        sink_gap_pct = 17;
      end else begin
        src_gap_pct  = 0;
        sink_gap_pct = 0;
      end
      send_random_word();
    end
    in_bus.valid <= 1'b0;

    // drain, then wait on for any stray beat
    while (board.due_answers.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
